// ----- rtl/core/clcd_seq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_seq_pkg: shared types, constants and helpers
// Request kinds, register map, byte layout and burst format used by the
// character display expander byte sequencer.
// ----------------------------------------------------------------------------
package clcd_seq_pkg;

  localparam int MaxColumnsDefault = 40;
  localparam int MaxLinesDefault   = 4;

  // Longest burst one request can cause: a character plus an address command
  localparam int BurstLen = 8;
  localparam int CountW   = $clog2(BurstLen + 1);

  localparam logic [7:0] BitRs    = 8'h01;
  localparam logic [7:0] BitEn    = 8'h04;
  localparam logic [7:0] BitBl    = 8'h08;
  localparam logic [7:0] DdramCmd = 8'h80;

  localparam logic [6:0] DeviceAddressReset = 7'd39;
  localparam logic       BacklightReset     = 1'b0;
  localparam logic [5:0] ColumnsReset       = 6'd16;
  localparam logic [2:0] LinesReset         = 3'd2;

  typedef enum logic [2:0] {
    REQ_DATA_CHAR  = 3'd0,
    REQ_CMD_BYTE   = 3'd1,
    REQ_SET_CURSOR = 3'd2,
    REQ_CMD_NIBBLE = 3'd3,
    REQ_PIN_WRITE  = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_BACKLIGHT_ON   = 2'd1,
    REG_COLUMNS_IN_USE = 2'd2,
    REG_LINES_IN_USE   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       backlight_on;
    logic [5:0] columns_in_use;
    logic [2:0] lines_in_use;
  } cfg_t;

  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } burst_t;

  function automatic logic [7:0] line_base(input logic [1:0] ln);
    logic [7:0] b;
    case (ln)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ddram_cmd(input logic [1:0] ln, input logic [5:0] col);
    return DdramCmd | (8'(col) + line_base(ln));
  endfunction

  function automatic logic [7:0] mk_byte(input logic [3:0] nib, input logic rs,
                                         input logic en, input logic bl);
    return {nib, 4'h0} | (rs ? BitRs : 8'h00) | (en ? BitEn : 8'h00) |
           (bl ? BitBl : 8'h00);
  endfunction

  // Full byte as four words: high nibble strobed, then low nibble strobed
  function automatic logic [3:0][7:0] mk_full(input logic [7:0] v, input logic rs,
                                              input logic bl);
    logic [3:0][7:0] r;
    r[0] = mk_byte(v[7:4], rs, 1'b1, bl);
    r[1] = mk_byte(v[7:4], rs, 1'b0, bl);
    r[2] = mk_byte(v[3:0], rs, 1'b1, bl);
    r[3] = mk_byte(v[3:0], rs, 1'b0, bl);
    return r;
  endfunction

endpackage

// ----- rtl/core/clcd_seq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_seq_cfg: configuration register file
// APB-style write and read access to the four sequencer registers.
// ----------------------------------------------------------------------------
module clcd_seq_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output clcd_seq_pkg::cfg_t  cfg
);

  logic [6:0] device_address;
  logic       backlight_on;
  logic [5:0] columns_in_use;
  logic [2:0] lines_in_use;
  logic       wr;
  clcd_seq_pkg::reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = clcd_seq_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= clcd_seq_pkg::DeviceAddressReset;
      backlight_on   <= clcd_seq_pkg::BacklightReset;
      columns_in_use <= clcd_seq_pkg::ColumnsReset;
      lines_in_use   <= clcd_seq_pkg::LinesReset;
    end else if (wr) begin
      case (idx)
        clcd_seq_pkg::REG_DEVICE_ADDRESS: device_address <= pwdata[6:0];
        clcd_seq_pkg::REG_BACKLIGHT_ON:   backlight_on   <= pwdata[0];
        clcd_seq_pkg::REG_COLUMNS_IN_USE: columns_in_use <= pwdata[5:0];
        clcd_seq_pkg::REG_LINES_IN_USE:   lines_in_use   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      clcd_seq_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, device_address};
      clcd_seq_pkg::REG_BACKLIGHT_ON:   prdata = {31'd0, backlight_on};
      clcd_seq_pkg::REG_COLUMNS_IN_USE: prdata = {26'd0, columns_in_use};
      clcd_seq_pkg::REG_LINES_IN_USE:   prdata = {29'd0, lines_in_use};
      default:                          prdata = 32'd0;
    endcase
  end

  assign cfg.backlight_on   = backlight_on;
  assign cfg.columns_in_use = columns_in_use;
  assign cfg.lines_in_use   = lines_in_use;

endmodule

// ----- rtl/core/clcd_seq_build.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_seq_build: request decoder and cursor tracker
// Builds the whole word burst of one request and updates the cursor when
// the request is taken.
// ----------------------------------------------------------------------------
module clcd_seq_build #(
  parameter int MAX_COLUMNS = clcd_seq_pkg::MaxColumnsDefault,
  parameter int MAX_LINES   = clcd_seq_pkg::MaxLinesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [2:0]           req_type,
  input  logic [7:0]           value,
  input  logic [1:0]           line,
  input  logic [5:0]           column,
  input  logic                 register_select,
  input  clcd_seq_pkg::cfg_t   cfg,
  output clcd_seq_pkg::burst_t burst
);

  localparam logic [5:0] MaxCols  = 6'(MAX_COLUMNS);
  localparam logic [2:0] MaxLines = 3'(MAX_LINES);

  logic [1:0] cursor_line, cursor_line_next;
  logic [5:0] cursor_column, cursor_column_next;
  logic [5:0] eff_cols;
  logic [2:0] eff_lines;
  logic [6:0] col_inc;
  logic [2:0] line_inc;
  logic [1:0] wrap_line;
  logic       wrap;
  logic [5:0] clamp_col;
  logic [1:0] clamp_line;
  logic       bl;

  assign bl = cfg.backlight_on;

  // Saturate the size registers into the supported range
  assign eff_cols  = (cfg.columns_in_use == 6'd0) ? 6'd1 :
                     (cfg.columns_in_use > MaxCols) ? MaxCols : cfg.columns_in_use;
  assign eff_lines = (cfg.lines_in_use == 3'd0) ? 3'd1 :
                     (cfg.lines_in_use > MaxLines) ? MaxLines : cfg.lines_in_use;

  assign col_inc   = {1'b0, cursor_column} + 7'd1;
  assign wrap      = col_inc >= {1'b0, eff_cols};
  assign line_inc  = {1'b0, cursor_line} + 3'd1;
  assign wrap_line = (line_inc >= eff_lines) ? 2'd0 : line_inc[1:0];

  assign clamp_col  = (column >= eff_cols) ? (eff_cols - 6'd1) : column;
  assign clamp_line = ({1'b0, line} >= eff_lines) ? 2'(eff_lines - 3'd1) : line;

  always_comb begin
    burst              = '0;
    cursor_line_next   = cursor_line;
    cursor_column_next = cursor_column;
    case (clcd_seq_pkg::req_type_t'(req_type))
      clcd_seq_pkg::REQ_DATA_CHAR: begin
        burst.bytes[3:0] = clcd_seq_pkg::mk_full(value, 1'b1, bl);
        if (wrap) begin
          burst.bytes[7:4]   = clcd_seq_pkg::mk_full(
                                 clcd_seq_pkg::ddram_cmd(wrap_line, 6'd0), 1'b0, bl);
          burst.count        = clcd_seq_pkg::CountW'(8);
          cursor_line_next   = wrap_line;
          cursor_column_next = 6'd0;
        end else begin
          burst.count        = clcd_seq_pkg::CountW'(4);
          cursor_column_next = col_inc[5:0];
        end
      end
      clcd_seq_pkg::REQ_CMD_BYTE: begin
        burst.bytes[3:0] = clcd_seq_pkg::mk_full(value, 1'b0, bl);
        burst.count      = clcd_seq_pkg::CountW'(4);
      end
      clcd_seq_pkg::REQ_SET_CURSOR: begin
        burst.bytes[3:0]   = clcd_seq_pkg::mk_full(
                               clcd_seq_pkg::ddram_cmd(clamp_line, clamp_col), 1'b0, bl);
        burst.count        = clcd_seq_pkg::CountW'(4);
        cursor_line_next   = clamp_line;
        cursor_column_next = clamp_col;
      end
      clcd_seq_pkg::REQ_CMD_NIBBLE: begin
        burst.bytes[0] = clcd_seq_pkg::mk_byte(value[3:0], 1'b0, 1'b1, bl);
        burst.bytes[1] = clcd_seq_pkg::mk_byte(value[3:0], 1'b0, 1'b0, bl);
        burst.count    = clcd_seq_pkg::CountW'(2);
      end
      clcd_seq_pkg::REQ_PIN_WRITE: begin
        burst.bytes[0] = clcd_seq_pkg::mk_byte(value[3:0], register_select, 1'b0, bl);
        burst.count    = clcd_seq_pkg::CountW'(1);
      end
      default: ;  // unknown kind: no words, cursor kept
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_line   <= 2'd0;
      cursor_column <= 6'd0;
    end else if (take) begin
      cursor_line   <= cursor_line_next;
      cursor_column <= cursor_column_next;
    end
  end

endmodule

// ----- rtl/core/clcd_seq_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_seq_emit: burst register and output stage
// Holds one request's words; shifts out one word per cycle on tready.
// ----------------------------------------------------------------------------
module clcd_seq_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  clcd_seq_pkg::burst_t burst,
  output logic                 can_load,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [clcd_seq_pkg::BurstLen-1:0][7:0] bytes;
  logic [clcd_seq_pkg::CountW-1:0]        remain;
  logic                                   pop;

  assign m_axis_tvalid = remain != '0;
  assign m_axis_tdata  = bytes[0];
  assign m_axis_tlast  = remain == clcd_seq_pkg::CountW'(1);
  assign pop           = m_axis_tvalid && m_axis_tready;
  // Take a burst when empty or as the current one's last word leaves
  assign can_load      = !m_axis_tvalid || (m_axis_tlast && m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load) begin
      remain <= burst.count;
    end else if (pop) begin
      remain <= remain - clcd_seq_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
    end else if (pop) begin
      bytes <= {8'h00, bytes[clcd_seq_pkg::BurstLen-1:1]};
    end
  end

endmodule

// ----- rtl/core/char_lcd_expander_byte_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_expander_byte_sequencer: display request to expander word stream
// Top level: register file, request decoder with cursor, burst output stage.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (kind in tuser, operands in tdata).
// Each one becomes a burst of 0 to 8 expander words on the m_axis channel,
// tlast marking the final word of the burst; an unknown kind gives no words.
// A request is decoded in the cycle it is taken and its whole burst lands
// in the output register, so the first word is on m_axis in the next cycle.
// Words then leave the single output register one per cycle while the
// receiver is ready; a burst holds 1, 2, 4 or 8 words, and an unknown
// kind is taken but leaves a gap in the words on m_axis.
// A new request is taken in the same cycle the last word of the previous
// burst is taken, so back-to-back requests give a gapless word stream.
// When the receiver stalls, the current word holds and s_axis_tready stays
// low until the final word of the burst goes.
// The APB port holds device address, backlight and display size; write it
// only while no burst is pending. Reset restores the register defaults,
// puts the cursor at line 0 column 0 and empties the output stage.
// ----------------------------------------------------------------------------
module char_lcd_expander_byte_sequencer #(
  parameter int MAX_COLUMNS = clcd_seq_pkg::MaxColumnsDefault,
  parameter int MAX_LINES   = clcd_seq_pkg::MaxLinesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // value[7:0], line[9:8], column[15:10],
                                     // register_select[16], zero pad[23:17]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // expander_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  clcd_seq_pkg::cfg_t   cfg;
  clcd_seq_pkg::burst_t burst;
  logic                 take;
  logic                 can_load;

  assign s_axis_tready = can_load;
  assign take          = s_axis_tvalid && s_axis_tready;

  clcd_seq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clcd_seq_build #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_build (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .req_type        (s_axis_tuser),
    .value           (s_axis_tdata[7:0]),
    .line            (s_axis_tdata[9:8]),
    .column          (s_axis_tdata[15:10]),
    .register_select (s_axis_tdata[16]),
    .cfg             (cfg),
    .burst           (burst)
  );

  clcd_seq_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (take),
    .burst         (burst),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the display expander byte sequencer
// Drives display requests on the input stream and size settings over APB.
// Every expander word on the output stream is compared with hand-checked
// words or a cycle-free model of each request's burst, including cursor wrap.
// A short table of requests, most hand-checked, comes first. Random ones
// follow under several display sizes: in-range extremes and saturated values.
// ----------------------------------------------------------------------------
module tb_top;
  import clcd_seq_pkg::*;

  localparam int IDLE_PCT        = 35;
  localparam int DIR_ROWS        = 24;
  localparam int N_PHASES        = 7;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_AT        = 300;
  localparam int STALL_CYCLES    = 300;
  localparam int MAX_COLS        = 40;
  localparam int MAX_ROWS        = 4;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [7:0] DDRAM_SET     = 8'h80;
  localparam logic [7:0] LINE_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] line;
    logic [5:0] column;
    logic       rs;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0] xbyte;
    logic       last;
  } xp_word_t;

  // Table row: request plus hand-checked words, first word in the top used byte
  typedef struct packed {
    lcd_req_t    req;
    logic        typed;
    logic [3:0]  nwords;
    logic [63:0] words;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_expander_byte_sequencer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Model state: register copies and cursor
  logic [6:0] addr_cfg;
  logic       bl_cfg;
  logic [5:0] cols_cfg;
  logic [2:0] lines_cfg;
  logic [1:0] cur_line;
  logic [5:0] cur_col;

  logic [7:0] burst_q [$];
  xp_word_t   words_due [$];
  dir_row_t   dir_tab [DIR_ROWS];

  int  errors      = 0;
  int  reqs_taken  = 0;
  int  words_taken = 0;
  int  wraps       = 0;
  int  stall_left  = 0;
  bit  stall_done  = 0;
  bit  calm        = 0;

  function automatic int eff_cols();
    if (cols_cfg == 6'd0) return 1;
    if (int'(cols_cfg) > MAX_COLS) return MAX_COLS;
    return int'(cols_cfg);
  endfunction

  function automatic int eff_lines();
    if (lines_cfg == 3'd0) return 1;
    if (int'(lines_cfg) > MAX_ROWS) return MAX_ROWS;
    return int'(lines_cfg);
  endfunction

  // Byte layout: nibble, backlight, enable, read/write low, RS
  function automatic void put_nib(input logic [3:0] nib, input logic rs);
    burst_q.push_back({nib, bl_cfg, 1'b1, 1'b0, rs});
    burst_q.push_back({nib, bl_cfg, 1'b0, 1'b0, rs});
  endfunction

  function automatic void put_full(input logic [7:0] v, input logic rs);
    put_nib(v[7:4], rs);
    put_nib(v[3:0], rs);
  endfunction

  function automatic void put_ddram();
    put_full(DDRAM_SET | (8'(cur_col) + LINE_BASE[cur_line]), 1'b0);
  endfunction

  // Fill burst_q with the words one request causes and advance the cursor
  function automatic void predict_burst(input lcd_req_t r);
    int ln;
    int col;
    burst_q.delete();
    case (r.kind)
      REQ_DATA_CHAR: begin
        put_full(r.value, 1'b1);
        if (int'(cur_col) + 1 >= eff_cols()) begin
          cur_line = (int'(cur_line) + 1 >= eff_lines()) ? 2'd0 : cur_line + 2'd1;
          cur_col  = 6'd0;
          wraps++;
          put_ddram();
        end else begin
          cur_col = cur_col + 6'd1;
        end
      end
      REQ_CMD_BYTE: put_full(r.value, 1'b0);
      REQ_SET_CURSOR: begin
        ln  = int'(r.line);
        col = int'(r.column);
        if (col >= eff_cols()) col = eff_cols() - 1;
        if (ln >= eff_lines()) ln = eff_lines() - 1;
        cur_line = 2'(ln);
        cur_col  = 6'(col);
        put_ddram();
      end
      REQ_CMD_NIBBLE: put_nib(r.value[3:0], 1'b0);
      REQ_PIN_WRITE: burst_q.push_back({r.value[3:0], bl_cfg, 1'b0, 1'b0, r.rs});
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] kind, input logic [7:0] value,
                                      input logic [1:0] line, input logic [5:0] column,
                                      input logic rs, input logic typed, input int n,
                                      input logic [63:0] words);
    dir_row_t row;
    row.req.kind   = kind;
    row.req.value  = value;
    row.req.line   = line;
    row.req.column = column;
    row.req.rs     = rs;
    row.typed      = typed;
    row.nwords     = 4'(n);
    row.words      = words;
    return row;
  endfunction

  function automatic lcd_req_t rand_req();
    lcd_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.kind = REQ_DATA_CHAR;
    else if (pick < 60) r.kind = REQ_SET_CURSOR;
    else if (pick < 72) r.kind = REQ_CMD_BYTE;
    else if (pick < 84) r.kind = REQ_CMD_NIBBLE;
    else if (pick < 95) r.kind = REQ_PIN_WRITE;
    else                r.kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    r.value  = 8'($urandom_range(0, 255));
    r.line   = 2'($urandom_range(0, 3));
    r.column = 6'($urandom_range(0, 63));
    r.rs     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Offer one request; return at the edge that takes it with tvalid still high
  task automatic offer(input lcd_req_t r, input logic typed, input logic [3:0] n,
                       input logic [63:0] words);
    int cnt;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r.rs, r.column, r.line, r.value};
    s_axis_tuser  <= r.kind;
    @(negedge clk);
    while (s_axis_tready !== 1'b1) @(negedge clk);
    predict_burst(r);
    if (typed) begin
      for (int i = 0; i < int'(n); i++)
        words_due.push_back({words[8*(int'(n)-1-i) +: 8], i == int'(n) - 1});
    end else begin
      cnt = burst_q.size();
      for (int i = 0; i < cnt; i++)
        words_due.push_back({burst_q[i], i == cnt - 1});
    end
    reqs_taken++;
    @(posedge clk);
  endtask

  // Drop tvalid and wait out every pending word plus the output latency
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (pready !== 1'b1) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEVICE_ADDRESS: addr_cfg  = val[6:0];
      REG_BACKLIGHT_ON:   bl_cfg    = val[0];
      REG_COLUMNS_IN_USE: cols_cfg  = val[5:0];
      REG_LINES_IN_USE:   lines_cfg = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_size(input logic [6:0] dev, input logic bl, input logic [5:0] cols,
                          input logic [2:0] lines);
    apb_write(REG_DEVICE_ADDRESS, 32'(dev));
    apb_write(REG_BACKLIGHT_ON, 32'(bl));
    apb_write(REG_COLUMNS_IN_USE, 32'(cols));
    apb_write(REG_LINES_IN_USE, 32'(lines));
  endtask

  // Receiver: random stalls, one long hold-off once enough words have gone
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!stall_done && words_taken >= STALL_AT) begin
        stall_done = 1;
        stall_left = STALL_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Check each output handshake on the falling edge before the edge that takes it
  always @(negedge clk) begin
    xp_word_t due;
    if (rst === 1'b0 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (words_due.size() == 0) begin
        $error("expander_byte: expected none, got %h", m_axis_tdata);
        errors++;
      end else begin
        due = words_due.pop_front();
        if (m_axis_tdata !== due.xbyte) begin
          $error("expander_byte: expected %h, got %h", due.xbyte, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== due.last) begin
          $error("last: expected %b, got %b", due.last, m_axis_tlast);
          errors++;
        end
      end
      words_taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    addr_cfg  = DeviceAddressReset;
    bl_cfg    = BacklightReset;
    cols_cfg  = ColumnsReset;
    lines_cfg = LinesReset;
    cur_line  = 2'd0;
    cur_col   = 6'd0;

    // Reset size is 16 columns by 2 lines, backlight off
    dir_tab[0]  = mk_row(REQ_PIN_WRITE,  8'h0F, 2'd0, 6'd0,  1'b1, 1'b1, 1, 64'hF1);
    dir_tab[1]  = mk_row(REQ_PIN_WRITE,  8'hF0, 2'd3, 6'd63, 1'b0, 1'b1, 1, 64'h00);
    dir_tab[2]  = mk_row(REQ_CMD_NIBBLE, 8'hA3, 2'd0, 6'd0,  1'b0, 1'b1, 2, 64'h3430);
    dir_tab[3]  = mk_row(REQ_CMD_BYTE,   8'hFF, 2'd0, 6'd0,  1'b0, 1'b1, 4, 64'hF4F0F4F0);
    dir_tab[4]  = mk_row(REQ_CMD_BYTE,   8'h00, 2'd3, 6'd63, 1'b1, 1'b1, 4, 64'h04000400);
    dir_tab[5]  = mk_row(REQ_DATA_CHAR,  8'h41, 2'd0, 6'd0,  1'b0, 1'b1, 4, 64'h45411511);
    dir_tab[6]  = mk_row(REQ_DATA_CHAR,  8'hFF, 2'd3, 6'd63, 1'b1, 1'b1, 4, 64'hF5F1F5F1);
    // Clamp both line and column to the display size
    dir_tab[7]  = mk_row(REQ_SET_CURSOR, 8'h00, 2'd3, 6'd63, 1'b0, 1'b1, 4, 64'hC4C0F4F0);
    // Last column of the last line: wrap to the top plus an address command
    dir_tab[8]  = mk_row(REQ_DATA_CHAR,  8'h7E, 2'd0, 6'd0,  1'b0, 1'b1, 8,
                         64'h7571E5E1_84800400);
    dir_tab[9]  = mk_row(REQ_UNUSED_LO,  8'h00, 2'd0, 6'd0,  1'b0, 1'b1, 0, 64'h0);
    dir_tab[10] = mk_row(REQ_UNUSED_HI,  8'hFF, 2'd3, 6'd63, 1'b1, 1'b1, 0, 64'h0);
    dir_tab[11] = mk_row(REQ_SET_CURSOR, 8'hFF, 2'd2, 6'd5,  1'b1, 1'b1, 4, 64'hC4C05450);
    dir_tab[12] = mk_row(REQ_SET_CURSOR, 8'h00, 2'd0, 6'd15, 1'b0, 1'b1, 4, 64'h8480F4F0);
    dir_tab[13] = mk_row(REQ_DATA_CHAR,  8'h00, 2'd0, 6'd0,  1'b0, 1'b1, 8,
                         64'h05010501_C4C00400);
    dir_tab[14] = mk_row(REQ_SET_CURSOR, 8'h00, 2'd1, 6'd16, 1'b0, 1'b1, 4, 64'hC4C0F4F0);
    dir_tab[15] = mk_row(REQ_DATA_CHAR,  8'h30, 2'd0, 6'd0,  1'b0, 1'b1, 8,
                         64'h35310501_84800400);
    dir_tab[16] = mk_row(REQ_CMD_NIBBLE, 8'hFF, 2'd0, 6'd0,  1'b0, 1'b1, 2, 64'hF4F0);
    dir_tab[17] = mk_row(REQ_PIN_WRITE,  8'h5A, 2'd0, 6'd0,  1'b1, 1'b1, 1, 64'hA1);
    dir_tab[18] = mk_row(REQ_CMD_BYTE,   8'h01, 2'd0, 6'd0,  1'b0, 1'b1, 4, 64'h04001410);
    dir_tab[19] = mk_row(REQ_SET_CURSOR, 8'h00, 2'd1, 6'd14, 1'b0, 1'b0, 0, 64'h0);
    dir_tab[20] = mk_row(REQ_DATA_CHAR,  8'h20, 2'd0, 6'd0,  1'b0, 1'b0, 0, 64'h0);
    dir_tab[21] = mk_row(REQ_DATA_CHAR,  8'h7F, 2'd1, 6'd1,  1'b1, 1'b0, 0, 64'h0);
    dir_tab[22] = mk_row(REQ_DATA_CHAR,  8'hAA, 2'd2, 6'd40, 1'b1, 1'b0, 0, 64'h0);
    dir_tab[23] = mk_row(REQ_PIN_WRITE,  8'hFF, 2'd3, 6'd63, 1'b1, 1'b1, 1, 64'hF1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].nwords, dir_tab[i].words);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: set_size(7'd0,   1'b1, 6'd1,  3'd1);
        1: set_size(7'd127, 1'b0, 6'd40, 3'd4);
        2: set_size(7'($urandom_range(0, 127)), 1'b1, 6'd0,  3'd0);
        3: set_size(7'($urandom_range(0, 127)), 1'b0, 6'd63, 3'd7);
        // Shrink under a cursor left far to the right
        4: set_size(7'($urandom_range(0, 127)), 1'b1, 6'd8,  3'd3);
        default: set_size(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                          6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
      endcase
      calm = (ph == 1);
      repeat (ITEMS_PER_PHASE) offer(rand_req(), 1'b0, 4'd0, 64'h0);
      drain();
    end

    $display("Run covered %0d requests (%0d from the table) over %0d display sizes,",
             reqs_taken, DIR_ROWS, N_PHASES + 1);
    $display("%0d expander words checked, %0d line wraps, one %0d-cycle output hold-off.",
             words_taken, wraps, STALL_CYCLES);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
